@@ src/dtt_pkg.sv @@
package dtt_pkg;

    localparam int ENTRIES     = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SCAN_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RES_IDX_W   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] KIND_SCHEDULE   = 3'd0;
    localparam logic [2:0] KIND_CANCEL_ID  = 3'd1;
    localparam logic [2:0] KIND_CANCEL_OH  = 3'd2;
    localparam logic [2:0] KIND_DROP_OWNER = 3'd3;
    localparam logic [2:0] KIND_TICK       = 3'd4;
    localparam logic [2:0] KIND_QUERY      = 3'd5;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FIRED     = 3'd3;
    localparam logic [2:0] ST_NOT_DUE   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic        used;
        logic [31:0] id;
        logic [7:0]  owner;
        logic [15:0] handle;
        logic [30:0] remaining;
        logic        idle;
    } t_slot;

    typedef struct packed {
        logic [2:0]  kind;
        logic [30:0] delay_ms;
        logic        is_idle;
        logic [7:0]  owner;
        logic [15:0] script_handle;
        logic [31:0] target_id;
        logic [30:0] elapsed_ms;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] job_id;
        logic [7:0]  owner;
        logic [15:0] handle;
        logic        idle;
    } t_result;

    // Running scan state handed to the slot processor.
    typedef struct packed {
        logic        fire;
        logic        sched_done;
        logic        hit;
        logic        room;
        logic [31:0] new_id;
    } t_scan_ctl;

    typedef struct packed {
        logic push;
        logic hit;
        logic sched;
    } t_proc_st;

endpackage

@@ src/dtt_if.sv @@
interface dtt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [30:0] delay_ms;
    logic        is_idle;
    logic [7:0]  owner;
    logic [15:0] script_handle;
    logic [31:0] target_id;
    logic [30:0] elapsed_ms;

    modport source (output valid, kind, delay_ms, is_idle, owner, script_handle,
                    target_id, elapsed_ms, input ready);
    modport sink (input valid, kind, delay_ms, is_idle, owner, script_handle,
                  target_id, elapsed_ms, output ready);
endinterface

interface dtt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] job_id;
    logic [7:0]  fired_owner;
    logic [15:0] fired_handle;
    logic        job_idle;
    logic [30:0] next_due_ms;
    logic        last;

    modport source (output valid, status, job_id, fired_owner, fired_handle,
                    job_idle, next_due_ms, last, input ready);
    modport sink (input valid, status, job_id, fired_owner, fired_handle,
                  job_idle, next_due_ms, last, output ready);
endinterface

@@ src/dtt_cell.sv @@
module dtt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  dtt_pkg::t_slot i_slot,
    output dtt_pkg::t_slot o_slot
);

    dtt_pkg::t_slot r_slot;

    // Only the used flag is reset; the rest of the slot is written before it is read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.used <= 1'b0;
        end else if (i_shift) begin
            r_slot.used <= i_slot.used;
        end
        if (i_shift) begin
            r_slot.id        <= i_slot.id;
            r_slot.owner     <= i_slot.owner;
            r_slot.handle    <= i_slot.handle;
            r_slot.remaining <= i_slot.remaining;
            r_slot.idle      <= i_slot.idle;
        end
    end

    assign o_slot = r_slot;

endmodule

@@ src/dtt_proc.sv @@
module dtt_proc (
    input  dtt_pkg::t_item     i_item,
    input  dtt_pkg::t_scan_ctl i_ctl,
    input  dtt_pkg::t_slot     i_slot,
    output dtt_pkg::t_slot     o_slot,
    output dtt_pkg::t_result   o_res,
    output dtt_pkg::t_proc_st  o_st
);

    logic id_match;
    logic own_match;

    assign id_match  = i_slot.used && (i_slot.id == i_item.target_id);
    assign own_match = i_slot.used && (i_slot.owner == i_item.owner);

    always_comb begin
        o_slot = i_slot;
        o_res  = '{status: dtt_pkg::ST_FIRED, job_id: i_slot.id, owner: i_slot.owner,
                   handle: i_slot.handle, idle: i_slot.idle};
        o_st   = '0;
        unique case (i_item.kind)
            dtt_pkg::KIND_SCHEDULE: begin
                if (!i_slot.used && !i_ctl.sched_done) begin
                    o_slot.used      = 1'b1;
                    o_slot.id        = i_ctl.new_id;
                    o_slot.owner     = i_item.owner;
                    o_slot.handle    = i_item.script_handle;
                    o_slot.idle      = i_item.is_idle;
                    o_slot.remaining = i_item.is_idle ? 31'd0 : i_item.delay_ms;
                    o_st.sched       = 1'b1;
                end
            end
            dtt_pkg::KIND_CANCEL_ID: begin
                if (id_match && !i_ctl.hit) begin
                    o_slot.used = 1'b0;
                    o_st.hit    = 1'b1;
                end
            end
            dtt_pkg::KIND_CANCEL_OH: begin
                if (own_match && i_slot.handle == i_item.script_handle) begin
                    o_slot.used = 1'b0;
                    o_st.hit    = 1'b1;
                end
            end
            dtt_pkg::KIND_DROP_OWNER: begin
                if (own_match) begin
                    o_slot.used = 1'b0;
                end
            end
            dtt_pkg::KIND_TICK: begin
                if (i_ctl.fire && i_slot.used) begin
                    if (!i_slot.idle && i_slot.remaining > i_item.elapsed_ms) begin
                        o_slot.remaining = i_slot.remaining - i_item.elapsed_ms;
                    end else if (i_ctl.room) begin
                        o_slot.used = 1'b0;
                        o_st.push   = 1'b1;
                    end else begin
                        o_slot.remaining = 31'd0;
                    end
                end
            end
            dtt_pkg::KIND_QUERY: begin
                if (id_match && !i_ctl.hit) begin
                    o_res.status = dtt_pkg::ST_DONE;
                    o_st.push    = 1'b1;
                    o_st.hit     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ src/deferred_timer_table.sv @@
// Each item makes one full turn of the slot ring, which visits every slot
// once in slot order; then its result items leave in order as they are taken.
// A single item is in flight at a time.
// Synchronous active-low reset empties every slot and clears the id counter
// and the cached next deadline; no clearing pass is needed.
module deferred_timer_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtt_in_if.sink     i_in,
    dtt_out_if.source  o_out
);

    localparam int E = dtt_pkg::ENTRIES;

    dtt_pkg::t_state r_state, n_state;

    dtt_pkg::t_item     r_item;
    dtt_pkg::t_slot     cell_in  [E];
    dtt_pkg::t_slot     cell_out [E];
    dtt_pkg::t_slot     proc_slot;
    dtt_pkg::t_result   proc_res;
    dtt_pkg::t_proc_st  proc_st;
    dtt_pkg::t_scan_ctl scan_ctl;

    dtt_pkg::t_result r_res [dtt_pkg::MAX_RESULTS];

    logic [31:0]                    r_last_id;
    logic [30:0]                    r_next_due;
    logic                           r_any_used;
    logic                           r_fire;
    logic                           r_sched_done;
    logic                           r_hit;
    logic [dtt_pkg::RES_CNT_W-1:0]  r_cnt;
    logic [dtt_pkg::RES_IDX_W-1:0]  r_rd;
    logic [dtt_pkg::SCAN_W-1:0]     r_scan;
    logic [30:0]                    r_min;
    logic                           r_have;
    logic                           r_any_idle;

    logic [30:0] n_min;
    logic        n_have;
    logic        n_any_idle;
    logic        shift;
    logic        accept;
    logic        out_take;
    logic        scan_last;
    logic        emit_last;
    dtt_pkg::t_result emit_res;

    assign accept    = i_in.valid && i_in.ready;
    assign out_take  = o_out.valid && o_out.ready;
    assign shift     = (r_state == dtt_pkg::S_SCAN);
    assign scan_last = (r_scan == dtt_pkg::SCAN_W'(E - 1));
    assign emit_last = (r_cnt == '0) ||
                       ({1'b0, r_rd} == dtt_pkg::RES_CNT_W'(r_cnt - 1'b1));

    // The ring: slot i sits in cell E-1-i, so the head leaves in slot order
    // and a full turn restores the layout.
    assign cell_in[0] = proc_slot;
    for (genvar k = 0; k < E; k++) begin : g_ring
        if (k > 0) begin : g_link
            assign cell_in[k] = cell_out[k-1];
        end
        dtt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_slot  (cell_in[k]),
            .o_slot  (cell_out[k])
        );
    end

    assign scan_ctl.fire       = r_fire;
    assign scan_ctl.sched_done = r_sched_done;
    assign scan_ctl.hit        = r_hit;
    assign scan_ctl.room       = (r_cnt < dtt_pkg::RES_CNT_W'(dtt_pkg::MAX_RESULTS));
    assign scan_ctl.new_id     = r_last_id + 32'd1;

    dtt_proc u_proc (
        .i_item (r_item),
        .i_ctl  (scan_ctl),
        .i_slot (cell_out[E-1]),
        .o_slot (proc_slot),
        .o_res  (proc_res),
        .o_st   (proc_st)
    );

    // Deadline bookkeeping over the slots as they are written back.
    always_comb begin
        n_min      = r_min;
        n_have     = r_have;
        n_any_idle = r_any_idle;
        if (proc_slot.used) begin
            if (proc_slot.idle) begin
                n_any_idle = 1'b1;
            end
            if (!r_have || proc_slot.remaining < r_min) begin
                n_min  = proc_slot.remaining;
                n_have = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dtt_pkg::S_IDLE: if (accept) n_state = dtt_pkg::S_SCAN;
            dtt_pkg::S_SCAN: if (scan_last) n_state = dtt_pkg::S_EMIT;
            dtt_pkg::S_EMIT: if (out_take && emit_last) n_state = dtt_pkg::S_IDLE;
            default:         n_state = dtt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = (r_state == dtt_pkg::S_IDLE);
        o_out.valid = (r_state == dtt_pkg::S_EMIT);
    end

    // When nothing was pushed, the single result follows from the item kind.
    always_comb begin
        emit_res = '0;
        if (r_cnt != '0) begin
            emit_res = r_res[r_rd];
        end else begin
            case (r_item.kind)
                dtt_pkg::KIND_SCHEDULE: begin
                    emit_res.status = r_sched_done ? dtt_pkg::ST_DONE : dtt_pkg::ST_FULL;
                    emit_res.job_id = r_sched_done ? r_last_id : 32'd0;
                end
                dtt_pkg::KIND_CANCEL_ID,
                dtt_pkg::KIND_CANCEL_OH,
                dtt_pkg::KIND_QUERY:
                    emit_res.status = r_hit ? dtt_pkg::ST_DONE : dtt_pkg::ST_NOT_FOUND;
                dtt_pkg::KIND_TICK:
                    emit_res.status = r_fire ? dtt_pkg::ST_DONE : dtt_pkg::ST_NOT_DUE;
                default:
                    emit_res.status = dtt_pkg::ST_DONE;
            endcase
        end
    end

    assign o_out.status       = emit_res.status;
    assign o_out.job_id       = emit_res.job_id;
    assign o_out.fired_owner  = emit_res.owner;
    assign o_out.fired_handle = emit_res.handle;
    assign o_out.job_idle     = emit_res.idle;
    assign o_out.next_due_ms  = r_next_due;
    assign o_out.last         = emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dtt_pkg::S_IDLE;
            r_last_id    <= '0;
            r_next_due   <= '0;
            r_any_used   <= 1'b0;
            r_fire       <= 1'b0;
            r_sched_done <= 1'b0;
            r_hit        <= 1'b0;
            r_cnt        <= '0;
            r_rd         <= '0;
            r_scan       <= '0;
            r_min        <= '0;
            r_have       <= 1'b0;
            r_any_idle   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_fire       <= (i_in.kind == dtt_pkg::KIND_TICK) && r_any_used &&
                                (i_in.elapsed_ms >= r_next_due);
                r_sched_done <= 1'b0;
                r_hit        <= 1'b0;
                r_cnt        <= '0;
                r_rd         <= '0;
                r_scan       <= '0;
                r_min        <= '0;
                r_have       <= 1'b0;
                r_any_idle   <= 1'b0;
            end
            if (shift) begin
                r_scan     <= r_scan + 1'b1;
                r_min      <= n_min;
                r_have     <= n_have;
                r_any_idle <= n_any_idle;
                if (proc_st.sched) r_sched_done <= 1'b1;
                if (proc_st.hit) r_hit <= 1'b1;
                if (proc_st.push) r_cnt <= r_cnt + 1'b1;
                if (scan_last) begin
                    r_next_due <= n_any_idle ? 31'd0 : (n_have ? n_min : 31'd0);
                    r_any_used <= n_have;
                    if (r_sched_done || proc_st.sched) begin
                        r_last_id <= r_last_id + 32'd1;
                    end
                end
            end
            if (out_take && !emit_last) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= '{kind: i_in.kind, delay_ms: i_in.delay_ms, is_idle: i_in.is_idle,
                        owner: i_in.owner, script_handle: i_in.script_handle,
                        target_id: i_in.target_id, elapsed_ms: i_in.elapsed_ms};
        end
        if (shift && proc_st.push) begin
            r_res[r_cnt[dtt_pkg::RES_IDX_W-1:0]] <= proc_res;
        end
    end

endmodule

@@ verif/deferred_timer_table_test.sv @@
`timescale 1ns / 100ps

module deferred_timer_table_test;
    import dtt_pkg::*;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] job_id;
        logic [7:0]  owner;
        logic [15:0] handle;
        logic        idle;
        logic [30:0] next_due;
        logic        last;
    } t_expect;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dtt_in_if  job_in();
    dtt_out_if job_out();

    deferred_timer_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (job_in.sink),
        .o_out   (job_out.source)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the job table.
    logic        tbl_used [ENTRIES];
    logic [31:0] tbl_id [ENTRIES];
    logic [7:0]  tbl_owner [ENTRIES];
    logic [15:0] tbl_handle [ENTRIES];
    logic [30:0] tbl_left [ENTRIES];
    logic        tbl_idle [ENTRIES];
    logic [31:0] id_counter;
    logic [30:0] cached_due;

    t_expect pending_results[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      items_sent = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    task automatic add_result(input logic [2:0] st, input logic [31:0] id,
                              input logic [7:0] own, input logic [15:0] hnd,
                              input logic idl, inout t_expect batch[$]);
        t_expect e;
        e.status = st; e.job_id = id; e.owner = own; e.handle = hnd;
        e.idle = idl; e.next_due = '0; e.last = 1'b0;
        batch.push_back(e);
    endtask

    task automatic predict_item(input t_item it);
        t_expect batch[$];
        int      slot;
        logic    found;
        logic    have_min;
        logic [30:0] least;
        found = 1'b0;
        slot = -1;
        case (it.kind)
            KIND_SCHEDULE: begin
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!tbl_used[i]) slot = i;
                if (slot < 0) begin
                    add_result(ST_FULL, '0, '0, '0, 1'b0, batch);
                end else begin
                    id_counter = id_counter + 32'd1;
                    tbl_used[slot] = 1'b1;
                    tbl_id[slot] = id_counter;
                    tbl_owner[slot] = it.owner;
                    tbl_handle[slot] = it.script_handle;
                    tbl_idle[slot] = it.is_idle;
                    tbl_left[slot] = it.is_idle ? '0 : it.delay_ms;
                    add_result(ST_DONE, id_counter, '0, '0, 1'b0, batch);
                end
            end
            KIND_CANCEL_ID: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!found && tbl_used[i] && tbl_id[i] == it.target_id) begin
                        tbl_used[i] = 1'b0;
                        found = 1'b1;
                    end
                add_result(found ? ST_DONE : ST_NOT_FOUND, '0, '0, '0, 1'b0, batch);
            end
            KIND_CANCEL_OH, KIND_DROP_OWNER: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_used[i] && tbl_owner[i] == it.owner &&
                        (it.kind == KIND_DROP_OWNER ||
                         tbl_handle[i] == it.script_handle)) begin
                        tbl_used[i] = 1'b0;
                        found = 1'b1;
                    end
                add_result((it.kind == KIND_CANCEL_OH && !found) ? ST_NOT_FOUND : ST_DONE,
                           '0, '0, '0, 1'b0, batch);
            end
            KIND_TICK: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_used[i]) found = 1'b1;
                if (!found || it.elapsed_ms < cached_due) begin
                    add_result(ST_NOT_DUE, '0, '0, '0, 1'b0, batch);
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (tbl_used[i]) begin
                            if (!tbl_idle[i] && tbl_left[i] > it.elapsed_ms) begin
                                tbl_left[i] = tbl_left[i] - it.elapsed_ms;
                            end else if (batch.size() < MAX_RESULTS) begin
                                add_result(ST_FIRED, tbl_id[i], tbl_owner[i],
                                           tbl_handle[i], tbl_idle[i], batch);
                                tbl_used[i] = 1'b0;
                            end else begin
                                tbl_left[i] = '0;
                            end
                        end
                    end
                    if (batch.size() == 0)
                        add_result(ST_DONE, '0, '0, '0, 1'b0, batch);
                end
            end
            KIND_QUERY: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!found && tbl_used[i] && tbl_id[i] == it.target_id) begin
                        add_result(ST_DONE, tbl_id[i], tbl_owner[i], tbl_handle[i],
                                   tbl_idle[i], batch);
                        found = 1'b1;
                    end
                if (!found)
                    add_result(ST_NOT_FOUND, '0, '0, '0, 1'b0, batch);
            end
            default: add_result(ST_DONE, '0, '0, '0, 1'b0, batch);
        endcase

        // New deadline: zero if any job is idle, else the smallest remaining time.
        have_min = 1'b0;
        least = '0;
        found = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_used[i]) begin
                if (tbl_idle[i]) found = 1'b1;
                else if (!have_min || tbl_left[i] < least) begin
                    least = tbl_left[i];
                    have_min = 1'b1;
                end
            end
        cached_due = found ? '0 : least;
        foreach (batch[k]) begin
            batch[k].next_due = cached_due;
            batch[k].last = (k == batch.size() - 1);
            pending_results.push_back(batch[k]);
        end
    endtask

    initial begin
        job_in.valid = 1'b0;
        job_in.kind = '0;
        job_in.delay_ms = '0;
        job_in.is_idle = 1'b0;
        job_in.owner = '0;
        job_in.script_handle = '0;
        job_in.target_id = '0;
        job_in.elapsed_ms = '0;
        job_out.ready = 1'b0;
        for (int i = 0; i < ENTRIES; i++) tbl_used[i] = 1'b0;
        id_counter = '0;
        cached_due = '0;
    end

    // Valid stays high between back-to-back items and drops only while the sender idles.
    task automatic send_item(input t_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            job_in.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        predict_item(it);
        job_in.valid <= 1'b1;
        job_in.kind <= it.kind;
        job_in.delay_ms <= it.delay_ms;
        job_in.is_idle <= it.is_idle;
        job_in.owner <= it.owner;
        job_in.script_handle <= it.script_handle;
        job_in.target_id <= it.target_id;
        job_in.elapsed_ms <= it.elapsed_ms;
        do @(posedge i_clk); while (!job_in.ready);
        items_sent++;
    endtask

    function automatic t_item make_item(input logic [2:0] k, input logic [30:0] dly,
                                        input logic idl, input logic [7:0] own,
                                        input logic [15:0] hnd, input logic [31:0] tid,
                                        input logic [30:0] el);
        t_item it;
        it.kind = k; it.delay_ms = dly; it.is_idle = idl; it.owner = own;
        it.script_handle = hnd; it.target_id = tid; it.elapsed_ms = el;
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (job_out.valid && job_out.ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result status %0d id %h", $time,
                             job_out.status, job_out.job_id);
                    mismatches++;
                end else begin
                    t_expect e;
                    e = pending_results.pop_front();
                    if (job_out.status !== e.status || job_out.job_id !== e.job_id ||
                        job_out.fired_owner !== e.owner ||
                        job_out.fired_handle !== e.handle ||
                        job_out.job_idle !== e.idle ||
                        job_out.next_due_ms !== e.next_due || job_out.last !== e.last) begin
                        $display("%0t: expected st %0d id %h own %h hnd %h idl %b due %0d last %b",
                                 $time, e.status, e.job_id, e.owner, e.handle, e.idle,
                                 e.next_due, e.last);
                        $display("%0t:   actual st %0d id %h own %h hnd %h idl %b due %0d last %b",
                                 $time, job_out.status, job_out.job_id, job_out.fired_owner,
                                 job_out.fired_handle, job_out.job_idle, job_out.next_due_ms,
                                 job_out.last);
                        mismatches++;
                    end
                end
            end
            job_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        job_in.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 4) @(posedge i_clk);
    endtask

    // A random id that mostly names a live job.
    function automatic logic [31:0] pick_id();
        int live[$];
        for (int i = 0; i < ENTRIES; i++) if (tbl_used[i]) live.push_back(i);
        if (live.size() != 0 && $urandom_range(99) < 75)
            return tbl_id[live[$urandom_range(live.size() - 1)]];
        return $urandom();
    endfunction

    task automatic test_directed();
        send_item(make_item(KIND_TICK, '0, 1'b0, '0, '0, '0, '1));
        send_item(make_item(KIND_QUERY, '0, 1'b0, '0, '0, 32'hFFFF_FFFF, '0));
        send_item(make_item(KIND_SCHEDULE, '1, 1'b0, 8'hFF, 16'hFFFF, '0, '0));
        send_item(make_item(KIND_SCHEDULE, 31'd0, 1'b0, 8'h00, 16'h0000, '0, '0));
        send_item(make_item(KIND_SCHEDULE, 31'd500, 1'b1, 8'h12, 16'h3456, '0, '0));
        send_item(make_item(KIND_QUERY, '0, 1'b0, '0, '0, 32'd3, '0));
        send_item(make_item(KIND_TICK, '0, 1'b0, '0, '0, '0, 31'd0));
        for (int i = 0; i < ENTRIES + 1; i++)
            send_item(make_item(KIND_SCHEDULE, 31'd7, i[0], 8'd5, i[15:0], '0, '0));
        send_item(make_item(KIND_CANCEL_OH, '0, 1'b0, 8'd5, 16'd3, '0, '0));
        send_item(make_item(KIND_CANCEL_OH, '0, 1'b0, 8'd5, 16'd3, '0, '0));
        send_item(make_item(KIND_CANCEL_ID, '0, 1'b0, '0, '0, 32'd9, '0));
        send_item(make_item(KIND_CANCEL_ID, '0, 1'b0, '0, '0, 32'd9, '0));
        send_item(make_item(KIND_TICK, '0, 1'b0, '0, '0, '0, 31'd3));
        send_item(make_item(KIND_DROP_OWNER, '0, 1'b0, 8'hFF, '0, '0, '0));
        send_item(make_item(3'd6, '1, 1'b1, '1, '1, '1, '1));
        send_item(make_item(3'd7, '0, 1'b0, '0, '0, '0, '0));
        send_item(make_item(KIND_DROP_OWNER, '0, 1'b0, 8'd5, '0, '0, '0));
        send_item(make_item(KIND_TICK, '0, 1'b0, '0, '0, '0, '1));
    endtask

    task automatic test_random(input int count);
        t_item it;
        int    r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            it = make_item(KIND_SCHEDULE, 31'($urandom()), $urandom_range(99) < 15,
                           8'($urandom_range(3) == 0 ? $urandom() : $urandom_range(3)),
                           16'($urandom_range(3) == 0 ? $urandom() : $urandom_range(3)),
                           pick_id(), '0);
            if ($urandom_range(2) != 0) it.delay_ms = 31'($urandom_range(200));
            if (r < 35) it.kind = KIND_SCHEDULE;
            else if (r < 45) it.kind = KIND_CANCEL_ID;
            else if (r < 52) it.kind = KIND_CANCEL_OH;
            else if (r < 56) it.kind = KIND_DROP_OWNER;
            else if (r < 85) begin
                it.kind = KIND_TICK;
                it.elapsed_ms = 31'(($urandom_range(3) == 0) ? $urandom() :
                                    cached_due + $urandom_range(60) - 10);
            end else if (r < 97) it.kind = KIND_QUERY;
            else it.kind = 3'($urandom_range(7));
            send_item(it);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(60);
        // Pause until the table has answered everything before the next phase.
        wait_drained();
        send_idle_pct = 70;
        test_random(100);
        send_idle_pct = 0;
        recv_stall_pct = 70;
        test_random(100);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        test_random(100);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(90);
        wait_drained();
        $display("Sent %0d items and checked %0d results: schedule, cancel, drop,", items_sent,
                 results_seen);
        $display("query, firing and idle ticks, full table and unused kinds, with back-pressure.");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
